>>> sv/pbps_pkg.sv
// shared types and constants of the pixel bit pattern scanner
package pbps_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned MASK_W  = 24;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // one classified pixel: flag bit j marks the stream bit 23+j of prev and cur
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [PIX_W-1:0]  cur_pix;
    logic [PIX_W-1:0]  prev_pix;
    logic [POS_W-1:0]  cur_col;
    logic [POS_W-1:0]  cur_row;
    logic [POS_W-1:0]  prev_col;
    logic [POS_W-1:0]  prev_row;
  } entry_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic [Q_PTR_W:0] count;
  } q_status_t;

endpackage

>>> sv/pbps_front.sv
// front end: accepts pixels, tracks position and builds the flag mask
module pbps_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [pbps_pkg::DIM_W-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic [pbps_pkg::PIX_W-1:0] in_pix_i,
  input  logic                    q_full_i,
  output logic                    in_ready_o,
  output logic                    push_o,
  output pbps_pkg::entry_t        push_entry_o
);
  import pbps_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [PIX_W-1:0] prev_q;
  logic             have_prev_q;
  logic [POS_W-1:0] col_q, row_q;
  logic [2*PIX_W-1:0] combo;
  logic [MASK_W-1:0] mask;
  logic [DIM_W-1:0] pcol, prow;
  logic [DIM_W-1:0] cur_rb, prev_rb;
  logic [DIM_W-1:0] col_nx, row_nx;

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  assign w_eff = clamp(width_q);
  assign h_eff = clamp(height_q);
  assign combo = {prev_q, in_pix_i};

  // stream position s lives at combo bit 47-s; flag j covers position 23+j
  always_comb begin
    for (int j = 0; j < MASK_W; j++) begin
      logic b0, b1, b2, b3;
      b0 = combo[2*PIX_W-1-(21+j)];
      b1 = combo[2*PIX_W-1-(22+j)];
      b2 = combo[2*PIX_W-1-(23+j)];
      b3 = combo[2*PIX_W-1-(24+j)];
      mask[j] = (b0 == b1) && (b2 != b1) && (b3 == b1) && (have_prev_q || j >= 3);
    end
  end

  always_comb begin
    if (col_q != '0) begin
      pcol = {1'b0, col_q} - DIM_W'(1);
      prow = {1'b0, row_q};
    end else begin
      pcol = w_eff - DIM_W'(1);
      prow = (row_q != '0) ? ({1'b0, row_q} - DIM_W'(1)) : '0;
    end
    cur_rb  = h_eff - DIM_W'(1) - {1'b0, row_q};
    prev_rb = h_eff - DIM_W'(1) - prow;
    col_nx  = {1'b0, col_q} + DIM_W'(1);
    row_nx  = {1'b0, row_q} + DIM_W'(1);
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_entry_o.mask     = mask;
    push_entry_o.cur_pix  = in_pix_i;
    push_entry_o.prev_pix = prev_q;
    push_entry_o.cur_col  = col_q;
    push_entry_o.cur_row  = cur_rb[POS_W-1:0];
    push_entry_o.prev_col = pcol[POS_W-1:0];
    push_entry_o.prev_row = prev_rb[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DIM_W'(1);
      height_q    <= DIM_W'(1);
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    width_q  <= cfg_data_i;
      endcase
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
    end else if (push_o) begin
      prev_q      <= in_pix_i;
      have_prev_q <= 1'b1;
      if (col_nx >= w_eff) begin
        col_q <= '0;
        if (row_nx >= h_eff) begin
          // image end: next pixel starts a fresh scan
          row_q       <= '0;
          prev_q      <= '0;
          have_prev_q <= 1'b0;
        end else begin
          row_q <= row_nx[POS_W-1:0];
        end
      end else begin
        col_q <= col_nx[POS_W-1:0];
      end
    end
  end

endmodule

>>> sv/pbps_queue.sv
// small queue of classified pixels between front and back end
module pbps_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pbps_pkg::entry_t    push_entry_i,
  input  logic                pop_i,
  output pbps_pkg::entry_t    head_o,
  output pbps_pkg::q_status_t status_o
);
  import pbps_pkg::*;

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q, cnt_d;

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.count = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + (Q_PTR_W+1)'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - (Q_PTR_W+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + Q_PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + Q_PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/pbps_back.sv
// back end: walks the flag mask of the head entry, one warning per cycle while the output is not stalled
module pbps_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbps_pkg::entry_t    head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbps_pkg::result_t   out_o
);
  import pbps_pkg::*;

  logic [MASK_W-1:0] done_q, done_d;
  logic [MASK_W-1:0] mask_eff, lowest, flip;
  logic              only, slot_free, emit;
  logic              out_valid_q;
  result_t           out_q, res;

  assign mask_eff  = head_i.mask & ~done_q;
  assign lowest    = mask_eff & (~mask_eff + MASK_W'(1));
  assign only      = ((mask_eff & ~lowest) == '0);
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = head_valid_i && (mask_eff != '0) && slot_free;
  assign pop_o     = head_valid_i && ((mask_eff == '0) || (emit && only));

  // flag j >= 1 sits at bit 24-j of the current pixel, msb first
  always_comb begin
    flip = '0;
    for (int i = 1; i < PIX_W; i++) flip[i] = lowest[PIX_W-i];
  end

  always_comb begin
    logic [PIX_W-1:0] pix;
    if (lowest[0]) begin
      pix        = head_i.prev_pix ^ PIX_W'(1);
      res.column = head_i.prev_col;
      res.row    = head_i.prev_row;
    end else begin
      pix        = head_i.cur_pix ^ flip;
      res.column = head_i.cur_col;
      res.row    = head_i.cur_row;
    end
    res.red   = pix[23:16];
    res.green = pix[15:8];
    res.blue  = pix[7:0];
    res.last  = only;
  end

  always_comb begin
    done_d = done_q;
    if (pop_o) done_d = '0;
    else if (emit) done_d = done_q | lowest;
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> sv/pixel_bit_pattern_scanner.sv
// top level of the pixel bit pattern scanner
// Pixels enter on the s_axis stream in stored order, top row first; each
// item carries red, green and blue. The pixels form one bit stream, channel
// msb first, and every bit framed as 0010 or 1101 by a four-bit window gives
// one warning item on m_axis: column, bottom-origin row and the pixel colour
// with that bit inverted. tlast marks the last warning caused by one pixel.
// Image size is set on the cfg port (index 0 width, index 1 height); a write
// restarts the scan and is meant to happen while the block is idle.
// With the queue empty, an accepted pixel is written into the queue, and its
// first warning is then registered in the back end output register.
// The back end walks the flag mask one result per cycle while m_axis is not
// stalled, so the warnings of a pixel leave one after another, up to eight
// per pixel; a pixel with no warnings is popped without output. A four-entry
// queue lets pixels enter while earlier warnings still drain.
// Reset clears the scan position, the queue and the output valid flag and sets
// both dimensions to 1. When m_axis_tready is low the result holds, the
// queue fills and s_axis_tready drops once it is full.
module pixel_bit_pattern_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // column, row, warn_red, warn_green, warn_blue
  output logic        m_axis_tlast   // last_warning
);
  import pbps_pkg::*;

  logic      push, pop;
  entry_t    push_entry, head;
  q_status_t q_st;
  result_t   res;
  logic [PIX_W-1:0] in_pix;

  assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  pbps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_pix_i     (in_pix),
    .q_full_i     (q_st.full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  pbps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_st)
  );

  pbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_st.empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {res.blue, res.green, res.red, res.row, res.column};
  assign m_axis_tlast = res.last;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_st.empty))
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.count <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !q_st.full)
    else $error("input ready disagrees with queue state");

endmodule
